>>> rtl/rsl_pkg.sv
// ----------------------------------------------------------------------------
// rsl_pkg
// shared types and constants for the sprite line run-length pixel extractor
// ----------------------------------------------------------------------------
package rsl_pkg;

  localparam int unsigned CoordBitsDefault = 16;

  localparam int unsigned PosW   = 16;  // line position
  localparam int unsigned WposW  = 17;  // signed wanted position
  localparam int unsigned CountW = 15;  // wanted count, line width
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgLineWidth = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgRunMode   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgOriginX   = 2'd2;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_DATA  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    PH_SKIP = 2'd0,
    PH_LEN  = 2'd1,
    PH_LIT  = 2'd2,
    PH_FILL = 2'd3
  } phase_e;

  typedef struct packed {
    logic               command;
    logic [ByteW-1:0]   data_byte;
    logic signed [15:0] start_x;
    logic [CountW-1:0]  want_count;
  } in_beat_t;

  typedef struct packed {
    logic              span_valid;
    logic [14:0]       span_x;
    logic [ByteW-1:0]  span_length;
    logic [ByteW-1:0]  pixel_value;
    logic              line_done;
  } out_beat_t;

  typedef struct packed {
    logic [CountW-1:0]  line_width;
    logic               run_type_bit_mode;
    logic signed [15:0] origin_x;
  } cfg_t;

  typedef struct packed {
    phase_e             phase;
    logic [PosW-1:0]    line_pos;
    logic [ByteW-1:0]   run_left;
    logic [WposW-1:0]   want_pos;
    logic [CountW-1:0]  want_left;
    logic               finished;
  } line_state_t;

endpackage

>>> rtl/rle_sprite_line_pixel_extract.sv
// ----------------------------------------------------------------------------
// rle_sprite_line_pixel_extract
// walks one run-length coded sprite line and emits the spans of a pixel window
// ----------------------------------------------------------------------------
// A start beat (command 0) opens a line and loads the window: first pixel at
// start_x + origin_x and want_count pixels. Each data beat (command 1) is one
// byte of the line: skip byte, length byte, then the run body (literal bytes,
// or a single colour byte for a fill run when run_type_bit_mode is set and
// the length low bit is 1). Each beat that copies pixels or ends the line
// returns one result beat; other beats return nothing. The block takes one
// beat per clock unless stalled: a beat is held in an input register, decoded
// by one step of small adds and compares against the line state, and then
// lands in the result register. The only stall comes from the result register
// while the downstream side holds out_ready_i low. Configuration must be
// written only while the block is idle; the block itself does not enforce this.
module rle_sprite_line_pixel_extract import rsl_pkg::*; #(
  parameter int unsigned COORD_BITS = CoordBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  // byte / command input
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_beat_t            in_data_i,
  // span result output
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_beat_t           out_data_o
);

  cfg_t        cfg_q;
  logic        in_valid_q;
  in_beat_t    in_q;
  line_state_t st_q, st_d;
  logic        out_valid_q;
  out_beat_t   out_q, res;
  logic        res_valid;
  logic        advance;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgLineWidth: cfg_q.line_width        <= cfg_wdata_i[CountW-1:0];
        CfgRunMode:   cfg_q.run_type_bit_mode <= cfg_wdata_i[0];
        CfgOriginX:   cfg_q.origin_x          <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // the held beat moves on when the result register is free or draining
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  // one parse step per beat
  rsl_step #(
    .COORD_BITS (COORD_BITS)
  ) u_step (
    .cfg_i       (cfg_q),
    .st_i        (st_q),
    .beat_i      (in_q),
    .st_o        (st_d),
    .res_o       (res),
    .res_valid_o (res_valid)
  );

  // line state, idle after reset until a start beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.phase     <= PH_SKIP;
      st_q.line_pos  <= '0;
      st_q.run_left  <= '0;
      st_q.want_pos  <= '0;
      st_q.want_left <= '0;
      st_q.finished  <= 1'b1;
    end else if (advance) begin
      st_q <= st_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= res_valid;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // a copied span always carries at least one pixel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.span_valid |-> out_data_o.span_length != '0)
    else $error("span with zero length");

  // a live line always has pixels still wanted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !st_q.finished |-> st_q.want_left != '0)
    else $error("line active with no pixels wanted");

  // a held beat with a blocked result register must stall the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_valid_q && !out_ready_i |=> $stable(st_q))
    else $error("line state moved while stalled");

endmodule

>>> rtl/rsl_step.sv
// ----------------------------------------------------------------------------
// rsl_step
// next line state and result for one command or data byte
// ----------------------------------------------------------------------------
module rsl_step import rsl_pkg::*; #(
  parameter int unsigned COORD_BITS = CoordBitsDefault
) (
  input  cfg_t        cfg_i,
  input  line_state_t st_i,
  input  in_beat_t    beat_i,
  output line_state_t st_o,
  output out_beat_t   res_o,
  output logic        res_valid_o
);

  localparam int unsigned ExtW = WposW - COORD_BITS;

  logic [WposW-1:0]  start_ext;
  logic [WposW-1:0]  origin_ext;
  logic [ByteW-1:0]  b;
  logic [PosW:0]     skip_sum;
  logic [ByteW-1:0]  len;
  logic              lit_hit;
  logic [PosW:0]     fill_hi;
  logic              fill_hit;
  logic [PosW:0]     fill_avail;
  logic [ByteW-1:0]  avail8;
  logic [ByteW-1:0]  num;
  logic [CountW-1:0] left_nxt;
  logic              run_end;
  logic              done;

  assign start_ext  = {{ExtW{beat_i.start_x[COORD_BITS-1]}},
                       beat_i.start_x[COORD_BITS-1:0]};
  assign origin_ext = {{ExtW{cfg_i.origin_x[COORD_BITS-1]}},
                       cfg_i.origin_x[COORD_BITS-1:0]};
  assign b          = beat_i.data_byte;
  assign skip_sum   = {1'b0, st_i.line_pos} + {{(PosW+1-ByteW){1'b0}}, b};
  assign len        = cfg_i.run_type_bit_mode ? {1'b0, b[ByteW-1:1]} : b;

  // literal: wanted pixel sits exactly here
  assign lit_hit = (st_i.want_left != '0) && (st_i.want_pos == {1'b0, st_i.line_pos});

  // fill: wanted pixel inside [line_pos, line_pos + run_left)
  assign fill_hi    = {1'b0, st_i.line_pos} + {{(PosW+1-ByteW){1'b0}}, st_i.run_left};
  assign fill_hit   = (st_i.want_left != '0) && !st_i.want_pos[WposW-1]
                    && (st_i.want_pos[PosW-1:0] >= st_i.line_pos)
                    && ({1'b0, st_i.want_pos[PosW-1:0]} < fill_hi);
  assign fill_avail = fill_hi - {1'b0, st_i.want_pos[PosW-1:0]};
  assign avail8     = fill_avail[ByteW-1:0];
  assign num        = ({{(CountW-ByteW){1'b0}}, avail8} < st_i.want_left)
                    ? avail8 : st_i.want_left[ByteW-1:0];

  always_comb begin
    st_o        = st_i;
    res_o       = '0;
    run_end     = 1'b0;
    done        = 1'b0;
    left_nxt    = st_i.want_left;
    if (beat_i.command == CMD_START) begin
      st_o.phase     = PH_SKIP;
      st_o.line_pos  = '0;
      st_o.run_left  = '0;
      st_o.want_left = beat_i.want_count;
      st_o.want_pos  = start_ext + origin_ext;
      st_o.finished  = (beat_i.want_count == '0);
      done           = (beat_i.want_count == '0);
    end else if (!st_i.finished) begin
      unique case (st_i.phase)
        PH_SKIP: begin
          st_o.line_pos = skip_sum[PosW-1:0];
          if (skip_sum >= {2'b0, cfg_i.line_width}) begin
            st_o.finished = 1'b1;
            done          = 1'b1;
          end else begin
            st_o.phase = PH_LEN;
          end
        end
        PH_LEN: begin
          st_o.run_left = len;
          if (cfg_i.run_type_bit_mode && b[0]) begin
            st_o.phase = PH_FILL;
          end else if (len == '0) begin
            run_end = 1'b1;
          end else begin
            st_o.phase = PH_LIT;
          end
        end
        PH_LIT: begin
          if (lit_hit) begin
            res_o.span_valid  = 1'b1;
            res_o.span_x      = st_i.line_pos[14:0];
            res_o.span_length = ByteW'(1);
            res_o.pixel_value = b;
            st_o.want_pos     = st_i.want_pos + WposW'(1);
            left_nxt          = st_i.want_left - CountW'(1);
          end
          st_o.line_pos  = st_i.line_pos + PosW'(1);
          st_o.run_left  = st_i.run_left - ByteW'(1);
          st_o.want_left = left_nxt;
          if (left_nxt == '0) begin
            st_o.finished = 1'b1;
            done          = 1'b1;
          end else if (st_i.run_left == ByteW'(1)) begin
            run_end = 1'b1;
          end
        end
        PH_FILL: begin
          if (fill_hit) begin
            res_o.span_valid  = 1'b1;
            res_o.span_x      = st_i.want_pos[14:0];
            res_o.span_length = num;
            res_o.pixel_value = b;
            st_o.want_pos     = st_i.want_pos + {{(WposW-ByteW){1'b0}}, num};
            left_nxt          = st_i.want_left - {{(CountW-ByteW){1'b0}}, num};
          end
          st_o.line_pos  = fill_hi[PosW-1:0];
          st_o.run_left  = '0;
          st_o.want_left = left_nxt;
          if (left_nxt == '0) begin
            st_o.finished = 1'b1;
            done          = 1'b1;
          end else begin
            run_end = 1'b1;
          end
        end
        default: ;
      endcase
      if (run_end) begin
        st_o.phase = PH_SKIP;
        if (st_o.line_pos >= {1'b0, cfg_i.line_width}) begin
          st_o.finished = 1'b1;
          done          = 1'b1;
        end
      end
    end
    res_o.line_done = done;
    res_valid_o     = done | res_o.span_valid;
  end

endmodule
